### hw/rtl/lli_pkg.sv
// Package: widths and payload types for the 3D line-line intersection pipeline.
package lli_pkg;

   // Coordinate format and derived internal widths
   localparam int CW   = 16;           // coordinate width, signed fixed point
   localparam int DW   = CW + 1;       // pt2 - pt1
   localparam int PW   = DW + CW;      // d * dir2 partial product
   localparam int V3W  = PW + 1;       // v3 component
   localparam int V4W  = 2 * CW + 1;   // v4 component
   localparam int NUMW = V3W + V4W + 2; // v3.v4, signed
   localparam int NMW  = NUMW - 1;     // magnitude of v3.v4
   localparam int DENW = 2 * V4W + 1;  // v4.v4, unsigned
   localparam int QW   = 32;           // alpha quotient bits (Q16.16)
   localparam int AW   = QW + 1;       // signed alpha
   localparam int MW   = AW + CW;      // alpha * dir1

   localparam logic signed [AW-1:0] ALPHA_MAX = {2'b00, {(QW-1){1'b1}}};
   localparam logic signed [AW-1:0] ALPHA_MIN = {2'b11, {(QW-1){1'b0}}};

   typedef struct packed {
      logic signed [CW-1:0] pt1_x;
      logic signed [CW-1:0] pt1_y;
      logic signed [CW-1:0] pt1_z;
      logic signed [CW-1:0] dir1_x;
      logic signed [CW-1:0] dir1_y;
      logic signed [CW-1:0] dir1_z;
      logic signed [CW-1:0] pt2_x;
      logic signed [CW-1:0] pt2_y;
      logic signed [CW-1:0] pt2_z;
      logic signed [CW-1:0] dir2_x;
      logic signed [CW-1:0] dir2_y;
      logic signed [CW-1:0] dir2_z;
   } req_type;

   typedef struct packed {
      logic signed [CW-1:0] hit_x;
      logic signed [CW-1:0] hit_y;
      logic signed [CW-1:0] hit_z;
      logic                 no_intersection;
      logic                 saturated;
   } rsp_type;

   // One slot of the restoring divider pipeline
   typedef struct packed {
      logic            valid;
      logic [DENW-1:0] rem;
      logic [DENW-1:0] den;
      logic [QW-1:0]   nbits;   // numerator bits still to shift in
      logic [QW-1:0]   q;
      logic            ovf;     // quotient already known to exceed QW bits
      logic            neg;
      logic            zero;    // parallel directions
      logic [3*CW-1:0] p1;
      logic [3*CW-1:0] v1;
   } div_type;

endpackage

### hw/rtl/lli_div_step.sv
// One restoring-division step: one quotient bit per pipeline slot.
module lli_div_step import lli_pkg::*; (
   input  div_type d_in,
   output div_type d_out
);

   logic [DENW:0]   rem_s;
   logic [DENW:0]   diff;
   logic            ge;

   // shift in the next numerator bit, subtract when it fits
   always_comb begin
      rem_s = {d_in.rem, d_in.nbits[QW-1]};
      diff  = rem_s - {1'b0, d_in.den};
      ge    = rem_s >= {1'b0, d_in.den};
      d_out       = d_in;
      d_out.rem   = ge ? diff[DENW-1:0] : rem_s[DENW-1:0];
      d_out.nbits = {d_in.nbits[QW-2:0], 1'b0};
      d_out.q     = {d_in.q[QW-2:0], ge};
   end

endmodule

### hw/rtl/line_line_intersection_3d.sv
// Top level: fully pipelined 3D line-line intersection (closest point on line one).
// Accepts one request per clock while not stalled and returns one response per
// request, in order. The depth is set by the 32-slot restoring divider that forms
// alpha one quotient bit per stage; pt2 - pt1, cross and dot products, divider setup,
// alpha clamp, alpha*dir1 and the final add/clamp take the remaining nine stages.
// All stages advance together whenever the output register is empty or being taken,
// so a stall freezes the whole pipeline and req_ready equals that same condition.
module line_line_intersection_3d import lli_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic adv;

   // stage 1: operands and pt2 - pt1
   logic                 s1_valid_ff;
   logic signed [CW-1:0] s1_p1_ff[3], s1_v1_ff[3], s1_v2_ff[3];
   logic signed [DW-1:0] s1_d_ff[3];
   logic signed [CW-1:0] in_p1[3], in_v1[3], in_p2[3], in_v2[3];

   // stage 2: cross product partial products
   logic                   s2_valid_ff;
   logic signed [PW-1:0]   s2_pa_ff[3], s2_pb_ff[3];
   logic signed [2*CW-1:0] s2_qa_ff[3], s2_qb_ff[3];
   logic [3*CW-1:0]        s2_p1_ff, s2_v1_ff;

   // stage 3: v3 and v4
   logic                  s3_valid_ff;
   logic signed [V3W-1:0] s3_v3_ff[3];
   logic signed [V4W-1:0] s3_v4_ff[3];
   logic [3*CW-1:0]       s3_p1_ff, s3_v1_ff;

   // stage 4: dot product terms
   logic                    s4_valid_ff;
   logic signed [NUMW-3:0]  s4_n_ff[3];
   logic signed [2*V4W-1:0] s4_d_ff[3];
   logic [3*CW-1:0]         s4_p1_ff, s4_v1_ff;

   // stage 5: numerator and denominator
   logic                   s5_valid_ff;
   logic signed [NUMW-1:0] s5_num_ff;
   logic [DENW-1:0]        s5_den_ff;
   logic [3*CW-1:0]        s5_p1_ff, s5_v1_ff;
   logic signed [NUMW-1:0] num_in;
   logic signed [DENW-1:0] den_in;

   // divider slots
   div_type        div_ff[QW+1];
   div_type        div_nx[QW];
   div_type        div0_in;
   logic [NUMW-1:0] num_abs;
   logic [NMW-1:0]  nmag;

   // stage 7: clamped alpha
   logic                 s7_valid_ff, s7_sat_ff, s7_zero_ff;
   logic signed [AW-1:0] s7_alpha_ff;
   logic [3*CW-1:0]      s7_p1_ff, s7_v1_ff;
   logic signed [AW-1:0] alpha_in;
   logic                 asat_in;

   // stage 8: alpha * dir1
   logic                 s8_valid_ff, s8_sat_ff, s8_zero_ff;
   logic signed [MW-1:0] s8_prod_ff[3];
   logic [3*CW-1:0]      s8_p1_ff;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // unpack request
   always_comb begin
      in_p1[0] = req_data.pt1_x;  in_p1[1] = req_data.pt1_y;  in_p1[2] = req_data.pt1_z;
      in_v1[0] = req_data.dir1_x; in_v1[1] = req_data.dir1_y; in_v1[2] = req_data.dir1_z;
      in_p2[0] = req_data.pt2_x;  in_p2[1] = req_data.pt2_y;  in_p2[2] = req_data.pt2_z;
      in_v2[0] = req_data.dir2_x; in_v2[1] = req_data.dir2_y; in_v2[2] = req_data.dir2_z;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_valid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s7_valid_ff  <= div_ff[QW].valid;
         s8_valid_ff  <= s7_valid_ff;
         rsp_valid_ff <= s8_valid_ff;
      end
   end

   // per-axis front stages; component i pairs axes i+1 and i+2
   for (genvar i = 0; i < 3; i++) begin : g_axis
      localparam int IA = (i + 1) % 3;
      localparam int IB = (i + 2) % 3;
      logic signed [DW-1:0]   d_in;
      logic signed [PW-1:0]   pa_in, pb_in;
      logic signed [2*CW-1:0] qa_in, qb_in;
      logic signed [V3W-1:0]  v3_in;
      logic signed [V4W-1:0]  v4_in;
      logic signed [NUMW-3:0] n_in;
      logic signed [2*V4W-1:0] dd_in;

      assign d_in  = in_p2[i] - in_p1[i];
      assign pa_in = s1_d_ff[IA] * s1_v2_ff[IB];
      assign pb_in = s1_d_ff[IB] * s1_v2_ff[IA];
      assign qa_in = s1_v1_ff[IA] * s1_v2_ff[IB];
      assign qb_in = s1_v1_ff[IB] * s1_v2_ff[IA];
      assign v3_in = s2_pa_ff[i] - s2_pb_ff[i];
      assign v4_in = s2_qa_ff[i] - s2_qb_ff[i];
      assign n_in  = s3_v3_ff[i] * s3_v4_ff[i];
      assign dd_in = s3_v4_ff[i] * s3_v4_ff[i];

      always_ff @(posedge clock) begin
         if (adv) begin
            s1_p1_ff[i] <= in_p1[i];
            s1_v1_ff[i] <= in_v1[i];
            s1_v2_ff[i] <= in_v2[i];
            s1_d_ff[i]  <= d_in;
            s2_pa_ff[i] <= pa_in;
            s2_pb_ff[i] <= pb_in;
            s2_qa_ff[i] <= qa_in;
            s2_qb_ff[i] <= qb_in;
            s3_v3_ff[i] <= v3_in;
            s3_v4_ff[i] <= v4_in;
            s4_n_ff[i]  <= n_in;
            s4_d_ff[i]  <= dd_in;
         end
      end
   end

   // dot product sums
   assign num_in = NUMW'(s4_n_ff[0]) + NUMW'(s4_n_ff[1]) + NUMW'(s4_n_ff[2]);
   assign den_in = DENW'(s4_d_ff[0]) + DENW'(s4_d_ff[1]) + DENW'(s4_d_ff[2]);

   // carry line one's point and direction along
   always_ff @(posedge clock) begin
      if (adv) begin
         s2_p1_ff  <= {s1_p1_ff[2], s1_p1_ff[1], s1_p1_ff[0]};
         s2_v1_ff  <= {s1_v1_ff[2], s1_v1_ff[1], s1_v1_ff[0]};
         s3_p1_ff  <= s2_p1_ff;
         s3_v1_ff  <= s2_v1_ff;
         s4_p1_ff  <= s3_p1_ff;
         s4_v1_ff  <= s3_v1_ff;
         s5_p1_ff  <= s4_p1_ff;
         s5_v1_ff  <= s4_v1_ff;
         s5_num_ff <= num_in;
         s5_den_ff <= den_in;
      end
   end

   // divider setup: magnitude, overflow precheck, initial remainder
   always_comb begin
      num_abs       = s5_num_ff[NUMW-1] ? -s5_num_ff : s5_num_ff;
      nmag          = num_abs[NMW-1:0];
      div0_in.valid = s5_valid_ff;
      div0_in.neg   = s5_num_ff[NUMW-1];
      div0_in.den   = s5_den_ff;
      div0_in.zero  = s5_den_ff == '0;
      div0_in.ovf   = {16'b0, nmag} >= {s5_den_ff, 16'b0};
      div0_in.rem   = DENW'(nmag >> 16);
      div0_in.nbits = {nmag[15:0], 16'b0};
      div0_in.q     = '0;
      div0_in.p1    = s5_p1_ff;
      div0_in.v1    = s5_v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff[0].valid <= 1'b0;
      end else if (adv) begin
         div_ff[0] <= div0_in;
      end
   end

   // one quotient bit per slot
   for (genvar k = 0; k < QW; k++) begin : g_div
      lli_div_step u_step (
         .d_in  (div_ff[k]),
         .d_out (div_nx[k])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[k+1].valid <= 1'b0;
         end else if (adv) begin
            div_ff[k+1] <= div_nx[k];
         end
      end
   end

   // signed alpha with clamp to the Q16.16 range
   always_comb begin
      if (div_ff[QW].neg) begin
         asat_in  = div_ff[QW].ovf || (div_ff[QW].q > {1'b1, {(QW-1){1'b0}}});
         alpha_in = asat_in ? ALPHA_MIN : -$signed({1'b0, div_ff[QW].q});
      end else begin
         asat_in  = div_ff[QW].ovf || div_ff[QW].q[QW-1];
         alpha_in = asat_in ? ALPHA_MAX : $signed({1'b0, div_ff[QW].q});
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s7_alpha_ff <= alpha_in;
         s7_sat_ff   <= asat_in;
         s7_zero_ff  <= div_ff[QW].zero;
         s7_p1_ff    <= div_ff[QW].p1;
         s7_v1_ff    <= div_ff[QW].v1;
         s8_sat_ff   <= s7_sat_ff;
         s8_zero_ff  <= s7_zero_ff;
         s8_p1_ff    <= s7_p1_ff;
      end
   end

   // alpha * dir1 and final add/clamp per axis
   logic signed [CW-1:0] hit[3];
   logic                 clamp[3];

   for (genvar i = 0; i < 3; i++) begin : g_out
      logic signed [MW-1:0]    prod_in, adj;
      logic signed [MW-17:0]   t;
      logic signed [MW-16:0]   c;
      logic signed [CW-1:0]    p1c;

      assign prod_in = s7_alpha_ff * $signed(s7_v1_ff[CW*i +: CW]);
      // drop 16 fraction bits, truncating toward zero
      assign adj = s8_prod_ff[i] + $signed({{(MW-16){1'b0}}, {16{s8_prod_ff[i][MW-1]}}});
      assign t   = adj[MW-1:16];
      assign p1c = s8_p1_ff[CW*i +: CW];
      assign c   = t + p1c;

      always_comb begin
         if (c > (MW-15)'(2**(CW-1) - 1)) begin
            hit[i]   = {1'b0, {(CW-1){1'b1}}};
            clamp[i] = 1'b1;
         end else if (c < -(MW-15)'(2**(CW-1))) begin
            hit[i]   = {1'b1, {(CW-1){1'b0}}};
            clamp[i] = 1'b1;
         end else begin
            hit[i]   = c[CW-1:0];
            clamp[i] = 1'b0;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            s8_prod_ff[i] <= prod_in;
         end
      end
   end

   // response assembly; parallel lines give zeros
   always_comb begin
      if (s8_zero_ff) begin
         rsp_data_in = '0;
         rsp_data_in.no_intersection = 1'b1;
      end else begin
         rsp_data_in.hit_x           = hit[0];
         rsp_data_in.hit_y           = hit[1];
         rsp_data_in.hit_z           = hit[2];
         rsp_data_in.no_intersection = 1'b0;
         rsp_data_in.saturated       = s8_sat_ff || clamp[0] || clamp[1] || clamp[2];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

### hw/rtl/lli_checker.sv
// Port-level checker for the line-line intersection pipeline, bound to the top level.
module lli_checker import lli_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a waiting response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // pipeline moves whenever the output slot frees up
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("request ready does not follow output slot");

   // parallel result carries zero coordinates and no saturation
   a_parallel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.no_intersection |->
         rsp_data.hit_x == '0 && rsp_data.hit_y == '0 && rsp_data.hit_z == '0
         && !rsp_data.saturated)
      else $error("parallel response is not clean");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind line_line_intersection_3d lli_checker u_lli_checker (.*);
